@@ hw/rtl/bbpa_pkg.sv @@
package bbpa_pkg;

    localparam int NUM_BLOCKS  = 1024;
    localparam int WORD_W      = 32;
    localparam int BIT_W       = $clog2(WORD_W);
    localparam int ROWS        = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int HINT_W      = $clog2(NUM_BLOCKS + 1);
    localparam int BLK_W       = 10;
    localparam int IDX_W       = ROW_W + BIT_W;
    localparam int TAIL_BITS   = NUM_BLOCKS - (ROWS - 1) * WORD_W;
    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 2;

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } t_mode;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] idx;
    } t_ffz;

    // bits past the pool end in the last row read as used
    function automatic t_word tail_mask();
        t_word m;
        m = '0;
        for (int b = 0; b < WORD_W; b++) begin
            if (b >= TAIL_BITS) m[b] = 1'b1;
        end
        return m;
    endfunction

    localparam t_word TAIL_MASK = tail_mask();

endpackage

@@ hw/rtl/bbpa_ram.sv @@
module bbpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/bbpa_ffz.sv @@
module bbpa_ffz
    import bbpa_pkg::*;
(
    input  t_word i_word,
    output t_ffz  o_res
);

    always_comb begin
        o_res = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!i_word[i]) begin
                o_res.found = 1'b1;
                o_res.idx   = BIT_W'(i);
            end
        end
    end

endmodule

@@ hw/rtl/bitmap_block_pool_allocator_core.sv @@
// Bitmap block pool allocator. The used bits of the pool sit in a RAM of
// 32-bit rows; a search hint tells where the next allocate scan starts. One
// request is handled at a time. A free in the pool reads its row, clears the
// block's bit and passes the result on to the output register. An allocate
// scans from the hint row up, 1 to 32 rows, each row taking one RAM read
// and one evaluate step; an allocate with the hint at the pool end answers
// out of memory without a RAM read. The output register lets the next
// request be accepted while a result waits. Rows never written read as
// free through per-row valid flags, so no clearing pass runs after reset.
module bitmap_block_pool_allocator_core
    import bbpa_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [9:0] in_block
    input  logic [IN_TUSER_W-1:0]  i_s_tuser,   // [0] mode
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // [9:0] granted_block
    output logic [OUT_TUSER_W-1:0] o_m_tuser    // [0] out_of_memory, [1] bad_free
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_EVAL = 4'b0100,
        S_PUSH = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    t_mode                r_mode, n_mode;
    logic [BLK_W-1:0]     r_blk, n_blk;
    logic [ROW_W-1:0]     r_row, n_row;
    logic                 r_first, n_first;
    logic [HINT_W-1:0]    r_hint, n_hint;
    logic [ROWS-1:0]      r_row_vld, n_row_vld;
    logic [BLK_W-1:0]     r_res_grant, n_res_grant;
    logic                 r_res_oom, n_res_oom;
    logic                 r_res_bad, n_res_bad;
    logic                 r_out_vld, n_out_vld;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;
    logic [OUT_TUSER_W-1:0] r_out_user, n_out_user;

    logic                 w_we, w_re;
    t_word                w_wdata, w_rdata, w_row_word, w_scan_word, w_low_mask;
    t_ffz                 w_ffz;
    t_mode                w_in_mode;
    logic [BLK_W-1:0]     w_in_blk;
    logic [IDX_W-1:0]     w_found_idx;

    bbpa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROWS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_row),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_row),
        .o_rdata (w_rdata)
    );

    assign w_row_word  = r_row_vld[r_row] ? w_rdata : '0;
    assign w_low_mask  = (t_word'(1) << r_hint[BIT_W-1:0]) - t_word'(1);
    assign w_scan_word = w_row_word
                       | (r_first ? w_low_mask : '0)
                       | ((r_row == ROW_W'(ROWS - 1)) ? TAIL_MASK : '0);

    bbpa_ffz u_ffz (
        .i_word (w_scan_word),
        .o_res  (w_ffz)
    );

    assign w_in_mode   = t_mode'(i_s_tuser[0]);
    assign w_in_blk    = i_s_tdata[BLK_W-1:0];
    assign w_found_idx = {r_row, w_ffz.idx};
    assign o_s_tready  = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_blk       = r_blk;
        n_row       = r_row;
        n_first     = r_first;
        n_hint      = r_hint;
        n_row_vld   = r_row_vld;
        n_res_grant = r_res_grant;
        n_res_oom   = r_res_oom;
        n_res_bad   = r_res_bad;
        n_out_vld   = r_out_vld;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        w_we        = 1'b0;
        w_re        = 1'b0;
        w_wdata     = w_row_word;

        if (r_out_vld && i_m_tready) n_out_vld = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_mode      = w_in_mode;
                    n_blk       = w_in_blk;
                    n_first     = 1'b1;
                    n_res_grant = '0;
                    n_res_oom   = 1'b0;
                    n_res_bad   = 1'b0;
                    if (w_in_mode == MODE_ALLOC) begin
                        n_row = r_hint[BIT_W +: ROW_W];
                        if (r_hint == HINT_W'(NUM_BLOCKS)) begin
                            n_res_oom = 1'b1;
                            n_state   = S_PUSH;
                        end else begin
                            n_state = S_RD;
                        end
                    end else begin
                        n_row = w_in_blk[BIT_W +: ROW_W];
                        if (HINT_W'(w_in_blk) >= HINT_W'(NUM_BLOCKS)) begin
                            n_res_bad = 1'b1;
                            n_state   = S_PUSH;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_RD: begin
                w_re    = 1'b1;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (r_mode == MODE_ALLOC) begin
                    if (w_ffz.found) begin
                        w_we               = 1'b1;
                        w_wdata            = w_row_word | (t_word'(1) << w_ffz.idx);
                        n_row_vld[r_row]   = 1'b1;
                        n_res_grant        = BLK_W'(w_found_idx);
                        n_hint             = HINT_W'(w_found_idx) + HINT_W'(1);
                        n_state            = S_PUSH;
                    end else if (r_row == ROW_W'(ROWS - 1)) begin
                        n_hint    = HINT_W'(NUM_BLOCKS);
                        n_res_oom = 1'b1;
                        n_state   = S_PUSH;
                    end else begin
                        n_row   = r_row + ROW_W'(1);
                        n_first = 1'b0;
                        n_state = S_RD;
                    end
                end else begin
                    w_we             = 1'b1;
                    w_wdata          = w_row_word & ~(t_word'(1) << r_blk[BIT_W-1:0]);
                    n_row_vld[r_row] = 1'b1;
                    if (HINT_W'(r_blk) < r_hint) n_hint = HINT_W'(r_blk);
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!r_out_vld || i_m_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_data = OUT_TDATA_W'(r_res_grant);
                    n_out_user = {r_res_bad, r_res_oom};
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_hint    <= '0;
            r_row_vld <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_hint    <= n_hint;
            r_row_vld <= n_row_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_blk       <= n_blk;
        r_row       <= n_row;
        r_first     <= n_first;
        r_res_grant <= n_res_grant;
        r_res_oom   <= n_res_oom;
        r_res_bad   <= n_res_bad;
        r_out_data  <= n_out_data;
        r_out_user  <= n_out_user;
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    a_hint_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hint <= HINT_W'(NUM_BLOCKS))
        else $error("search hint past pool end");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && w_re))
        else $error("map read and write in the same cycle");

    a_scan_from_hint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && r_mode == MODE_ALLOC) |-> (r_row >= r_hint[BIT_W +: ROW_W]))
        else $error("allocate scan below hint row");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("out of memory and bad free together");

    a_fail_zero_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser[0] || o_m_tuser[1])) |-> (o_m_tdata == '0))
        else $error("failed request carries a block index");

endmodule

@@ bench/tb_bitmap_block_pool_allocator_core.sv @@
`timescale 1ns / 100ps

module tb_bitmap_block_pool_allocator_core;
    import bbpa_pkg::*;

    localparam int RANDOM_REQUESTS = 1880;
    localparam int QUIET_TAIL      = 150;
    localparam int FILL_START      = 400;
    localparam int FILL_OOM_COUNT  = 4;
    localparam int DRAIN_AT        = 1350;
    localparam int HOLD_OFF_AT     = 250;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DIRECTED_ROWS   = 17;

    typedef struct packed {
        logic [BLK_W-1:0] granted_block;
        logic             out_of_memory;
        logic             bad_free;
    } t_grant;

    typedef struct packed {
        t_mode            mode;
        logic [BLK_W-1:0] in_block;
        logic             typed;
        t_grant           grant;
    } t_directed_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;   // [9:0] in_block
    logic [IN_TUSER_W-1:0]  i_s_tuser;   // [0] mode
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;   // [9:0] granted_block
    logic [OUT_TUSER_W-1:0] o_m_tuser;   // [0] out_of_memory, [1] bad_free

    logic [NUM_BLOCKS-1:0] pool_used;
    logic [HINT_W-1:0]     scan_hint;
    t_grant                grant_q[$];
    logic [BLK_W-1:0]      held_blocks[$];
    int                    fail_count;
    int                    results_seen;
    int                    oom_predicted;
    int                    stall_pct;
    int                    idle_cycles;
    bit                    quiet_tail;

    t_directed_row directed_table [DIRECTED_ROWS] = '{
        '{MODE_ALLOC, 10'd0,    1'b1, '{10'd0, 1'b0, 1'b0}},
        '{MODE_ALLOC, 10'd1023, 1'b1, '{10'd1, 1'b0, 1'b0}},
        '{MODE_ALLOC, 10'd0,    1'b1, '{10'd2, 1'b0, 1'b0}},
        '{MODE_FREE,  10'd1,    1'b1, '{10'd0, 1'b0, 1'b0}},
        '{MODE_ALLOC, 10'd682,  1'b1, '{10'd1, 1'b0, 1'b0}},
        '{MODE_ALLOC, 10'd341,  1'b1, '{10'd3, 1'b0, 1'b0}},
        '{MODE_FREE,  10'd1023, 1'b1, '{10'd0, 1'b0, 1'b0}},
        '{MODE_FREE,  10'd0,    1'b1, '{10'd0, 1'b0, 1'b0}},
        '{MODE_ALLOC, 10'd0,    1'b1, '{10'd0, 1'b0, 1'b0}},
        '{MODE_ALLOC, 10'd0,    1'b1, '{10'd4, 1'b0, 1'b0}},
        '{MODE_FREE,  10'd682,  1'b1, '{10'd0, 1'b0, 1'b0}},
        '{MODE_FREE,  10'd341,  1'b1, '{10'd0, 1'b0, 1'b0}},
        '{MODE_FREE,  10'd2,    1'b1, '{10'd0, 1'b0, 1'b0}},
        '{MODE_FREE,  10'd2,    1'b1, '{10'd0, 1'b0, 1'b0}},
        '{MODE_ALLOC, 10'd0,    1'b1, '{10'd2, 1'b0, 1'b0}},
        '{MODE_ALLOC, 10'd0,    1'b1, '{10'd5, 1'b0, 1'b0}},
        '{MODE_FREE,  10'd1023, 1'b0, '{10'd0, 1'b0, 1'b0}}
    };

    bitmap_block_pool_allocator_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic t_grant predict_grant(t_mode mode, logic [BLK_W-1:0] blk);
        t_grant grant;
        logic   hit;
        grant = '0;
        hit   = 1'b0;
        if (mode == MODE_ALLOC) begin
            for (int i = int'(scan_hint); i < NUM_BLOCKS; i++) begin
                if (!hit && !pool_used[i]) begin
                    pool_used[i]        = 1'b1;
                    grant.granted_block = BLK_W'(i);
                    scan_hint           = HINT_W'(i + 1);
                    hit                 = 1'b1;
                end
            end
            if (!hit) begin
                scan_hint           = HINT_W'(NUM_BLOCKS);
                grant.out_of_memory = 1'b1;
            end
        end else if (int'(blk) >= NUM_BLOCKS) begin
            grant.bad_free = 1'b1;
        end else begin
            if (HINT_W'(blk) < scan_hint) scan_hint = HINT_W'(blk);
            pool_used[blk] = 1'b0;
        end
        return grant;
    endfunction

    task automatic send_request(t_mode mode, logic [BLK_W-1:0] blk, logic typed,
                                t_grant typed_grant);
        t_grant predicted;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_TDATA_W'(blk);
        i_s_tuser  <= mode;
        do @(posedge i_clk); while (!o_s_tready);
        predicted = predict_grant(mode, blk);
        if (predicted.out_of_memory) oom_predicted++;
        if (mode == MODE_ALLOC && !predicted.out_of_memory)
            held_blocks.push_back(predicted.granted_block);
        grant_q.push_back(typed ? typed_grant : predicted);
    endtask

    task automatic sender_gap(int gap_pct);
        int cycles;
        cycles = (!quiet_tail && $urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 12) : 0;
        if (cycles > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    initial begin : request_source
        int               seg_end;
        int               alloc_pct;
        int               gap_pct;
        int               pct;
        int               oom_mark;
        int               k;
        bit               filling;
        t_mode            mode;
        logic [BLK_W-1:0] blk;
        pool_used     = '0;
        scan_hint     = '0;
        fail_count    = 0;
        oom_predicted = 0;
        stall_pct     = 20;
        quiet_tail    = 1'b0;
        seg_end       = 0;
        alloc_pct     = 50;
        gap_pct       = 20;
        oom_mark      = 0;
        filling       = 1'b0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= MODE_ALLOC;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            send_request(directed_table[r].mode, directed_table[r].in_block,
                         directed_table[r].typed, directed_table[r].grant);
            sender_gap(gap_pct);
        end

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == seg_end) begin
                seg_end = n + $urandom_range(40, 160);
                case ($urandom_range(0, 3))
                    0: alloc_pct = 15;
                    1: alloc_pct = 50;
                    2: alloc_pct = 80;
                    default: alloc_pct = 95;
                endcase
                gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : 25;
                stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
            end
            if (n == FILL_START) begin
                filling  = 1'b1;
                oom_mark = oom_predicted;
            end
            if (filling && oom_predicted >= oom_mark + FILL_OOM_COUNT) filling = 1'b0;
            if (n >= RANDOM_REQUESTS - QUIET_TAIL) quiet_tail = 1'b1;
            // hold until every pending grant is back
            if (n == DRAIN_AT) begin
                i_s_tvalid <= 1'b0;
                while (grant_q.size() != 0) @(posedge i_clk);
            end
            pct = filling ? 98 : alloc_pct;
            if ($urandom_range(0, 99) < pct) begin
                mode = MODE_ALLOC;
                blk  = BLK_W'($urandom);
            end else begin
                mode = MODE_FREE;
                if (held_blocks.size() > 0 && $urandom_range(0, 99) < 85) begin
                    k   = $urandom_range(0, held_blocks.size() - 1);
                    blk = held_blocks[k];
                    held_blocks.delete(k);
                end else begin
                    blk = BLK_W'($urandom);
                end
            end
            send_request(mode, blk, 1'b0, '0);
            sender_gap(gap_pct);
        end

        i_s_tvalid <= 1'b0;
        while (grant_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : result_pacing
        bit held_off;
        held_off = 1'b0;
        i_m_tready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            if (!held_off && results_seen >= HOLD_OFF_AT) begin
                held_off = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    initial results_seen = 0;

    always @(posedge i_clk) begin : grant_check
        t_grant expected;
        if (i_rst_n === 1'b1 && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (grant_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual tdata %h tuser %h",
                         $time, o_m_tdata, o_m_tuser);
                fail_count++;
            end else begin
                expected = grant_q.pop_front();
                if (o_m_tdata[BLK_W-1:0] !== expected.granted_block) begin
                    $display("%0t: granted_block expected %0d actual %0d",
                             $time, expected.granted_block, o_m_tdata[BLK_W-1:0]);
                    fail_count++;
                end
                if (o_m_tuser[0] !== expected.out_of_memory) begin
                    $display("%0t: out_of_memory expected %b actual %b",
                             $time, expected.out_of_memory, o_m_tuser[0]);
                    fail_count++;
                end
                if (o_m_tuser[1] !== expected.bad_free) begin
                    $display("%0t: bad_free expected %b actual %b",
                             $time, expected.bad_free, o_m_tuser[1]);
                    fail_count++;
                end
            end
        end
    end

    initial idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
